### rtl/cal_pkg.sv
// ----------------------------------------------------------------------------
// cal_pkg
// Types, codes and defaults shared by the cursor array list block.
// ----------------------------------------------------------------------------
package cal_pkg;

    localparam int DEF_CAPACITY      = 64;
    localparam int DEF_ELEMENT_WIDTH = 32;

    localparam int VALUE_W = 32;
    localparam int POS_W   = 7;
    localparam int LEN_W   = 7;

    typedef enum logic [3:0] {
        OP_INSERT = 4'd0,
        OP_APPEND = 4'd1,
        OP_REMOVE = 4'd2,
        OP_START  = 4'd3,
        OP_END    = 4'd4,
        OP_NEXT   = 4'd5,
        OP_PREV   = 4'd6,
        OP_MOVE   = 4'd7,
        OP_CLEAR  = 4'd8,
        OP_READ   = 4'd9
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_MOVE,
        S_PUT,
        S_FETCH,
        S_DONE
    } state_t;

    typedef struct packed {
        op_t                       kind;
        logic signed [VALUE_W-1:0] value;
        logic [POS_W-1:0]          position;
    } in_req_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] current_value;
        logic [LEN_W-1:0]          list_length;
        logic [LEN_W-1:0]          cursor_position;
        status_t                   status;
    } out_req_t;

    typedef struct packed {
        logic we;
        logic re;
    } mem_ctl_t;

endpackage

### rtl/cal_store.sv
// ----------------------------------------------------------------------------
// cal_store
// Element memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module cal_store
    import cal_pkg::*;
#(
    parameter int CAPACITY      = DEF_CAPACITY,
    parameter int ELEMENT_WIDTH = DEF_ELEMENT_WIDTH,
    localparam int ADDR_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
    input  logic                     aclk,
    input  mem_ctl_t                 ctl,
    input  logic [ADDR_W-1:0]        waddr,
    input  logic [ELEMENT_WIDTH-1:0] wdata,
    input  logic [ADDR_W-1:0]        raddr,
    output logic [ELEMENT_WIDTH-1:0] rdata
);

    logic [ELEMENT_WIDTH-1:0] mem [CAPACITY];
    logic [ELEMENT_WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (ctl.we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/cal_ctrl.sv
// ----------------------------------------------------------------------------
// cal_ctrl
// Sequencer: decodes a request, steps one shared +/-1 index unit to walk
// the tail through the store, writes any new word, then fetches the word at the cursor.
// ----------------------------------------------------------------------------
module cal_ctrl
    import cal_pkg::*;
#(
    parameter int CAPACITY      = DEF_CAPACITY,
    parameter int ELEMENT_WIDTH = DEF_ELEMENT_WIDTH,
    localparam int ADDR_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    localparam int CNT_W        = $clog2(CAPACITY + 1),
    localparam int CMP_W        = (CNT_W > POS_W) ? CNT_W : POS_W
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     req_valid,
    output logic                     req_ready,
    input  in_req_t                  req,
    output logic                     res_valid,
    input  logic                     res_ready,
    output out_req_t                 res,
    output mem_ctl_t                 mem_ctl,
    output logic [ADDR_W-1:0]        mem_waddr,
    output logic [ELEMENT_WIDTH-1:0] mem_wdata,
    output logic [ADDR_W-1:0]        mem_raddr,
    input  logic [ELEMENT_WIDTH-1:0] mem_rdata
);

    state_t state_reg, state_next, dispatch_state;

    logic [CNT_W-1:0]         count_reg, count_next;
    logic [CNT_W-1:0]         cursor_reg, cursor_next;
    status_t                  status_reg, status_next;
    logic [ADDR_W-1:0]        waddr_reg, waddr_next;
    logic [ADDR_W-1:0]        raddr_reg, raddr_next;
    logic [ADDR_W-1:0]        stop_reg, stop_next;
    logic [ADDR_W-1:0]        put_reg, put_next;
    logic                     down_reg, down_next;
    logic [ELEMENT_WIDTH-1:0] word_reg, word_next;

    logic [CNT_W-1:0] unit_a;
    logic             unit_down;
    logic [CNT_W-1:0] unit_y;

    logic             accept;
    logic             full;
    logic             at_end;
    logic             last_move;
    logic [CNT_W-1:0] count_inc;
    logic [CNT_W-1:0] count_dec;
    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] count_ext;

    logic [VALUE_W+ELEMENT_WIDTH-1:0] value_wide;
    logic [VALUE_W+ELEMENT_WIDTH-1:0] rdata_wide;
    logic [CNT_W+LEN_W-1:0]           count_wide;
    logic [CNT_W+LEN_W-1:0]           cursor_wide;

    assign accept    = req_valid && req_ready;
    assign full      = (count_reg == CNT_W'(CAPACITY));
    assign at_end    = (cursor_reg == count_reg);
    assign last_move = (raddr_reg == stop_reg);
    assign count_inc = count_reg + CNT_W'(1);
    assign count_dec = count_reg - CNT_W'(1);
    assign pos_ext   = CMP_W'(req.position);
    assign count_ext = CMP_W'(count_reg);

    assign value_wide = {{ELEMENT_WIDTH{1'b0}}, req.value};
    assign rdata_wide = {{VALUE_W{1'b0}}, mem_rdata};
    assign count_wide = {{LEN_W{1'b0}}, count_reg};
    assign cursor_wide = {{LEN_W{1'b0}}, cursor_reg};

    // shared index unit
    always_comb begin
        unit_a    = cursor_reg;
        unit_down = 1'b0;
        if (state_reg == S_MOVE) begin
            unit_a    = CNT_W'(raddr_reg);
            unit_down = down_reg;
        end else begin
            unique case (req.kind)
                OP_INSERT: begin
                    unit_a    = count_reg;
                    unit_down = 1'b1;
                end
                OP_PREV: unit_down = 1'b1;
                default: unit_down = 1'b0;
            endcase
        end
    end

    assign unit_y = unit_down ? (unit_a - CNT_W'(1)) : (unit_a + CNT_W'(1));

    // request decode and datapath registers
    always_comb begin
        dispatch_state = S_FETCH;
        count_next     = count_reg;
        cursor_next    = cursor_reg;
        status_next    = status_reg;
        waddr_next     = waddr_reg;
        raddr_next     = raddr_reg;
        stop_next      = stop_reg;
        put_next       = put_reg;
        down_next      = down_reg;
        word_next      = word_reg;
        if (accept) begin
            status_next = ST_OK;
            word_next   = value_wide[ELEMENT_WIDTH-1:0];
            unique case (req.kind)
                OP_INSERT: begin
                    if (full) begin
                        status_next = ST_RANGE;
                    end else begin
                        count_next = count_inc;
                        down_next  = 1'b1;
                        stop_next  = cursor_reg[ADDR_W-1:0];
                        put_next   = cursor_reg[ADDR_W-1:0];
                        if (at_end) begin
                            dispatch_state = S_PUT;
                        end else begin
                            waddr_next     = count_reg[ADDR_W-1:0];
                            raddr_next     = unit_y[ADDR_W-1:0];
                            dispatch_state = S_LOAD;
                        end
                    end
                end
                OP_APPEND: begin
                    if (full) begin
                        status_next = ST_RANGE;
                    end else begin
                        put_next       = count_reg[ADDR_W-1:0];
                        cursor_next    = count_reg;
                        count_next     = count_inc;
                        dispatch_state = S_PUT;
                    end
                end
                OP_REMOVE: begin
                    if (at_end) begin
                        status_next = ST_EMPTY;
                    end else begin
                        count_next = count_dec;
                        if (unit_y != count_reg) begin
                            down_next      = 1'b0;
                            waddr_next     = cursor_reg[ADDR_W-1:0];
                            raddr_next     = unit_y[ADDR_W-1:0];
                            stop_next      = count_dec[ADDR_W-1:0];
                            dispatch_state = S_LOAD;
                        end
                    end
                end
                OP_START: cursor_next = '0;
                OP_END:   cursor_next = count_reg;
                OP_NEXT: begin
                    if (at_end) begin
                        status_next = ST_RANGE;
                    end else begin
                        cursor_next = unit_y;
                    end
                end
                OP_PREV: begin
                    if (cursor_reg == '0) begin
                        status_next = ST_RANGE;
                    end else begin
                        cursor_next = unit_y;
                    end
                end
                OP_MOVE: begin
                    if (pos_ext > count_ext) begin
                        status_next = ST_RANGE;
                    end else begin
                        cursor_next = pos_ext[CNT_W-1:0];
                    end
                end
                OP_CLEAR: begin
                    count_next  = '0;
                    cursor_next = '0;
                end
                default: begin
                    if (at_end) begin
                        status_next = ST_EMPTY;
                    end
                end
            endcase
        end else if (state_reg == S_MOVE && !last_move) begin
            waddr_next = raddr_reg;
            raddr_next = unit_y[ADDR_W-1:0];
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (req_valid) state_next = dispatch_state;
            S_LOAD:  state_next = S_MOVE;
            S_MOVE: begin
                if (last_move) begin
                    state_next = down_reg ? S_PUT : S_FETCH;
                end
            end
            S_PUT:   state_next = S_FETCH;
            S_FETCH: state_next = S_DONE;
            S_DONE:  if (res_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        req_ready   = (state_reg == S_IDLE);
        res_valid   = (state_reg == S_DONE);
        mem_ctl.we  = 1'b0;
        mem_ctl.re  = 1'b0;
        mem_waddr   = waddr_reg;
        mem_wdata   = mem_rdata;
        mem_raddr   = raddr_reg;
        unique case (state_reg)
            S_LOAD: mem_ctl.re = 1'b1;
            S_MOVE: begin
                mem_ctl.we = 1'b1;
                mem_ctl.re = !last_move;
                mem_raddr  = unit_y[ADDR_W-1:0];
            end
            S_PUT: begin
                mem_ctl.we = 1'b1;
                mem_waddr  = put_reg;
                mem_wdata  = word_reg;
            end
            S_FETCH: begin
                mem_ctl.re = !at_end;
                mem_raddr  = cursor_reg[ADDR_W-1:0];
            end
            default: begin
                mem_ctl.we = 1'b0;
            end
        endcase
        res.current_value   = at_end ? '0 : rdata_wide[VALUE_W-1:0];
        res.list_length     = count_wide[LEN_W-1:0];
        res.cursor_position = cursor_wide[LEN_W-1:0];
        res.status          = status_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            cursor_reg <= '0;
            status_reg <= ST_OK;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            cursor_reg <= cursor_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge aclk) begin
        waddr_reg <= waddr_next;
        raddr_reg <= raddr_next;
        stop_reg  <= stop_next;
        put_reg   <= put_next;
        down_reg  <= down_next;
        word_reg  <= word_next;
    end

endmodule

### rtl/cursor_array_list_top.sv
// ----------------------------------------------------------------------------
// cursor_array_list_top
// Ordered list of words with a cursor, held in a single-port-pair memory.
// ----------------------------------------------------------------------------
// Each request carries one list operation and returns one response with the
// word at the cursor, the length, the cursor and a status. Requests are taken
// one at a time. Insert moves a tail unless the cursor is at the end, and
// remove moves one unless the cursor is on the last element; the tail is
// copied one element per cycle through the memory's read and write ports
// with one shared increment/decrement unit. The longest request is an insert
// at the head of a list one short of full. A response waits in an output
// register until taken.
module cursor_array_list_top
    import cal_pkg::*;
#(
    parameter int CAPACITY      = DEF_CAPACITY,
    parameter int ELEMENT_WIDTH = DEF_ELEMENT_WIDTH
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_req_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output out_req_t m_data
);

    localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    mem_ctl_t                 mem_ctl;
    logic [ADDR_W-1:0]        mem_waddr;
    logic [ELEMENT_WIDTH-1:0] mem_wdata;
    logic [ADDR_W-1:0]        mem_raddr;
    logic [ELEMENT_WIDTH-1:0] mem_rdata;

    logic     res_valid;
    logic     res_ready;
    out_req_t res;

    logic     m_valid_reg, m_valid_next;
    out_req_t m_data_reg, m_data_next;

    cal_ctrl #(
        .CAPACITY      (CAPACITY),
        .ELEMENT_WIDTH (ELEMENT_WIDTH)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_valid),
        .req_ready (s_ready),
        .req       (s_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_ctl   (mem_ctl),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    cal_store #(
        .CAPACITY      (CAPACITY),
        .ELEMENT_WIDTH (ELEMENT_WIDTH)
    ) u_store (
        .aclk  (aclk),
        .ctl   (mem_ctl),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
            m_data_next  = res;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

### test/cursor_array_list_top_tb.sv
// ----------------------------------------------------------------------------
// cursor_array_list_top_tb
// Drives list operations into the cursor array list and checks every response
// against a cycle-free model of the list or the expected values of directed rows.
// A table of directed requests covers the empty, single and full list, the
// edges of the cursor and every operation. Random traffic follows, in fill,
// drain and roaming stretches, under changing back-pressure on both sides.
// ----------------------------------------------------------------------------
module cursor_array_list_top_tb;
    import cal_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAP          = DEF_CAPACITY;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE       = 100;
    localparam int PHASE_ITEMS  = 270;
    localparam op_t OP_SPARE_LO = op_t'(4'd10);
    localparam op_t OP_SPARE_HI = op_t'(4'd15);

    typedef enum int {
        PACE_FILL,
        PACE_DRAIN,
        PACE_ROAM
    } pace_t;

    typedef struct packed {
        op_t             kind;
        logic [31:0]     value;
        logic [POS_W-1:0] position;
        int              reps;
        bit              known;
        out_req_t        golden;
    } drill_row_t;

    localparam out_req_t NO_GOLDEN = '0;

    localparam drill_row_t DRILL [32] = '{
        '{OP_READ,     32'h0,         7'd0,  1,  1'b1, '{32'h0, 7'd0, 7'd0, ST_EMPTY}},
        '{OP_REMOVE,   32'h0,         7'd0,  1,  1'b1, '{32'h0, 7'd0, 7'd0, ST_EMPTY}},
        '{OP_NEXT,     32'h0,         7'd0,  1,  1'b1, '{32'h0, 7'd0, 7'd0, ST_RANGE}},
        '{OP_PREV,     32'h0,         7'd0,  1,  1'b1, '{32'h0, 7'd0, 7'd0, ST_RANGE}},
        '{OP_MOVE,     32'h0,         7'd1,  1,  1'b1, '{32'h0, 7'd0, 7'd0, ST_RANGE}},
        '{OP_END,      32'h0,         7'd0,  1,  1'b1, '{32'h0, 7'd0, 7'd0, ST_OK}},
        '{OP_APPEND,   32'h7FFF_FFFF, 7'd0,  1,  1'b1,
          '{32'h7FFF_FFFF, 7'd1, 7'd0, ST_OK}},
        '{OP_APPEND,   32'h8000_0000, 7'd0,  1,  1'b1,
          '{32'h8000_0000, 7'd2, 7'd1, ST_OK}},
        '{OP_INSERT,   32'h0,         7'd0,  1,  1'b1, '{32'h0, 7'd3, 7'd1, ST_OK}},
        '{OP_START,    32'h0,         7'd0,  1,  1'b0, NO_GOLDEN},
        '{OP_INSERT,   32'hFFFF_FFFF, 7'd0,  1,  1'b0, NO_GOLDEN},
        '{OP_END,      32'h0,         7'd0,  1,  1'b1, '{32'h0, 7'd4, 7'd4, ST_OK}},
        '{OP_READ,     32'h0,         7'd0,  1,  1'b1, '{32'h0, 7'd4, 7'd4, ST_EMPTY}},
        '{OP_REMOVE,   32'h0,         7'd0,  1,  1'b1, '{32'h0, 7'd4, 7'd4, ST_EMPTY}},
        '{OP_NEXT,     32'h0,         7'd0,  1,  1'b1, '{32'h0, 7'd4, 7'd4, ST_RANGE}},
        '{OP_MOVE,     32'h0,         7'd5,  1,  1'b1, '{32'h0, 7'd4, 7'd4, ST_RANGE}},
        '{OP_PREV,     32'h0,         7'd0,  1,  1'b0, NO_GOLDEN},
        '{OP_REMOVE,   32'h0,         7'd0,  1,  1'b0, NO_GOLDEN},
        '{OP_MOVE,     32'h0,         7'd1,  1,  1'b0, NO_GOLDEN},
        '{OP_REMOVE,   32'h0,         7'd0,  1,  1'b0, NO_GOLDEN},
        '{OP_SPARE_HI, 32'h0,         7'd0,  1,  1'b0, NO_GOLDEN},
        '{OP_SPARE_LO, 32'h0,         7'd0,  1,  1'b0, NO_GOLDEN},
        '{OP_CLEAR,    32'h0,         7'd0,  1,  1'b1, '{32'h0, 7'd0, 7'd0, ST_OK}},
        '{OP_APPEND,   32'h1357_0000, 7'd0,  CAP, 1'b0, NO_GOLDEN},
        '{OP_APPEND,   32'h2468_ACE0, 7'd0,  1,  1'b0, NO_GOLDEN},
        '{OP_INSERT,   32'h2468_ACE1, 7'd0,  1,  1'b0, NO_GOLDEN},
        '{OP_MOVE,     32'h0,         7'd64, 1,  1'b1, '{32'h0, 7'd64, 7'd64, ST_OK}},
        '{OP_MOVE,     32'h0,         7'd0,  1,  1'b0, NO_GOLDEN},
        '{OP_REMOVE,   32'h0,         7'd0,  1,  1'b0, NO_GOLDEN},
        '{OP_INSERT,   32'h0F0F_0F0F, 7'd0,  1,  1'b0, NO_GOLDEN},
        '{OP_PREV,     32'h0,         7'd0,  1,  1'b0, NO_GOLDEN},
        '{OP_CLEAR,    32'h0,         7'd0,  1,  1'b1, '{32'h0, 7'd0, 7'd0, ST_OK}}
    };

    logic     aclk;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    in_req_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    out_req_t m_data;

    logic [31:0] shadow_words [CAP];
    int unsigned shadow_len;
    int unsigned shadow_cur;

    out_req_t pending_results [$];
    out_req_t want;

    int  tx_idle_pct;
    int  rx_idle_pct;
    int  hold_reqs;
    int  errors;
    int  checked;
    int  requests;
    int  directed;
    int  peak_len;
    int  full_refusals;

    cursor_array_list_top dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #5ms;
        $display("cursor_array_list_top_tb: FAIL");
        $finish;
    end

    function automatic out_req_t apply_list_op(input in_req_t r);
        out_req_t res;
        status_t  st;
        int       i;
        st = ST_OK;
        case (r.kind)
            OP_INSERT: begin
                if (shadow_len >= CAP) begin
                    st = ST_RANGE;
                end else begin
                    for (i = shadow_len; i > shadow_cur; i--)
                        shadow_words[i] = shadow_words[i-1];
                    shadow_words[shadow_cur] = r.value;
                    shadow_len++;
                end
            end
            OP_APPEND: begin
                if (shadow_len >= CAP) begin
                    st = ST_RANGE;
                end else begin
                    shadow_words[shadow_len] = r.value;
                    shadow_cur = shadow_len;
                    shadow_len++;
                end
            end
            OP_REMOVE: begin
                if (shadow_cur >= shadow_len) begin
                    st = ST_EMPTY;
                end else begin
                    for (i = shadow_cur; i + 1 < shadow_len; i++)
                        shadow_words[i] = shadow_words[i+1];
                    shadow_len--;
                end
            end
            OP_START: shadow_cur = 0;
            OP_END:   shadow_cur = shadow_len;
            OP_NEXT: begin
                if (shadow_cur >= shadow_len) st = ST_RANGE;
                else shadow_cur++;
            end
            OP_PREV: begin
                if (shadow_cur == 0) st = ST_RANGE;
                else shadow_cur--;
            end
            OP_MOVE: begin
                if (r.position > shadow_len) st = ST_RANGE;
                else shadow_cur = r.position;
            end
            OP_CLEAR: begin
                shadow_len = 0;
                shadow_cur = 0;
            end
            default: begin
                if (shadow_cur >= shadow_len) st = ST_EMPTY;
            end
        endcase
        res.current_value   = (shadow_cur < shadow_len) ? shadow_words[shadow_cur] : '0;
        res.list_length     = LEN_W'(shadow_len);
        res.cursor_position = LEN_W'(shadow_cur);
        res.status          = st;
        return res;
    endfunction

    function automatic in_req_t make_request(input pace_t pace);
        in_req_t r;
        int      roll;
        r.value    = $urandom;
        r.position = ($urandom_range(9) == 0) ? POS_W'($urandom_range(64))
                                              : POS_W'($urandom_range(shadow_len));
        r.kind     = ($urandom_range(5) == 0) ? OP_READ
                                              : op_t'(OP_START + $urandom_range(4));
        roll = $urandom_range(99);
        if (roll < 4) begin
            r.kind = op_t'($urandom_range(15));
        end else if (roll < 6) begin
            r.kind = OP_CLEAR;
        end else begin
            case (pace)
                PACE_FILL: begin
                    if (roll < 45) r.kind = OP_INSERT;
                    else if (roll < 75) r.kind = OP_APPEND;
                    else if (roll < 80) r.kind = OP_REMOVE;
                end
                PACE_DRAIN: begin
                    if (roll < 55) r.kind = OP_REMOVE;
                    else if (roll < 62) r.kind = OP_INSERT;
                end
                default: begin
                    if (roll < 22) r.kind = OP_INSERT;
                    else if (roll < 34) r.kind = OP_APPEND;
                    else if (roll < 52) r.kind = OP_REMOVE;
                end
            endcase
        end
        return r;
    endfunction

    task automatic issue_request(input in_req_t req, input bit known, input out_req_t golden);
        out_req_t predicted;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        predicted = apply_list_op(req);
        pending_results.push_back(known ? golden : predicted);
        requests++;
        if (shadow_len > peak_len) peak_len = shadow_len;
        if (predicted.status == ST_RANGE && (req.kind == OP_INSERT || req.kind == OP_APPEND))
            full_refusals++;
    endtask

    task automatic compare_field(input string name, input logic [31:0] exp, input logic [31:0] act);
        if (exp !== act) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp, act);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("response with no request outstanding: %p", m_data);
                errors++;
            end else begin
                want = pending_results.pop_front();
                checked++;
                compare_field("current_value", want.current_value, m_data.current_value);
                compare_field("list_length", want.list_length, m_data.list_length);
                compare_field("cursor_position", want.cursor_position,
                              m_data.cursor_position);
                compare_field("status", want.status, m_data.status);
            end
        end
    end

    initial begin : result_sink
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        forever begin
            @(posedge aclk);
            if (hold_reqs != hold_seen) begin
                hold_seen = hold_reqs;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    initial begin : stimulus
        drill_row_t row;
        in_req_t    req;
        pace_t      pace;
        int         seg_left;
        shadow_len  = 0;
        shadow_cur  = 0;
        seg_left    = 0;
        pace        = PACE_FILL;
        tx_idle_pct = 22;
        rx_idle_pct = 77;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (DRILL[i]) begin
            row = DRILL[i];
            for (int k = 0; k < row.reps; k++) begin
                req.kind     = row.kind;
                req.value    = row.value + k;
                req.position = row.position;
                issue_request(req, row.known, row.golden);
            end
        end
        directed = requests;

        for (int phase = 0; phase < 3; phase++) begin
            tx_idle_pct = (phase == 0) ? 22 : (phase == 1) ? 77 : 0;
            rx_idle_pct = (phase == 0) ? 77 : (phase == 1) ? 22 : 0;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (seg_left == 0) begin
                    pace     = pace_t'($urandom_range(2));
                    seg_left = $urandom_range(20, 60);
                end
                seg_left--;
                if (n == 50) hold_reqs++;
                if (n == 150) begin
                    s_valid <= 1'b0;
                    wait (pending_results.size() == 0);
                    @(posedge aclk);
                end
                issue_request(make_request(pace), 1'b0, NO_GOLDEN);
            end
        end

        s_valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (SETTLE) @(posedge aclk);

        $display("%0d requests (%0d directed), list peaked at %0d entries, %0d refused when full",
                 requests, directed, peak_len, full_refusals);
        $display("%0d responses compared, %0d mismatches", checked, errors);
        if (errors == 0) begin
            $display("cursor_array_list_top_tb: PASS");
        end else begin
            $display("cursor_array_list_top_tb: FAIL");
        end
        $finish;
    end

endmodule

### sim.f
rtl/cal_pkg.sv
rtl/cal_store.sv
rtl/cal_ctrl.sv
rtl/cursor_array_list_top.sv
test/cursor_array_list_top_tb.sv
